### hdl/wrr_pkg.sv
// Shared types and constants for the window receiver reorder block.
// No dependencies; used by the interfaces, the arithmetic unit and the top level.
package wrr_pkg;

  // Reorder ring depth. Must be a power of two: the slot index is the low sequence bits.
  localparam int WINDOW_MAX  = 32;
  localparam int PAYLOAD_MAX = 500;
  localparam int MAX_RESULTS = 34;

  localparam int IDX_W  = $clog2(WINDOW_MAX);
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int SEQ_W  = 32;
  localparam int LEN_W  = 9;
  localparam int PLEN_W = 16;
  localparam int WS_W   = 6;
  localparam int SLOT_W = SEQ_W + LEN_W;

  localparam logic [WS_W-1:0]   WS_RESET = 6'd8;
  localparam logic [PLEN_W-1:0] HDR_LEN  = 16'd12;
  localparam logic [PLEN_W-1:0] ACK_LEN  = 16'd8;
  localparam logic [PLEN_W-1:0] PLEN_MAX = PLEN_W'(12 + PAYLOAD_MAX);

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_EOF  = 2'd1;
  localparam logic [1:0] KIND_ACK  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LEN,
    S_SPACE,
    S_WIN,
    S_INORD,
    S_DRN_A,
    S_DRN_B,
    S_DRN_C,
    S_ACK,
    S_EOF
  } state_t;

  typedef enum logic [1:0] {
    ALU_SUB,
    ALU_SUBM1,
    ALU_INC
  } alu_op_t;

  typedef struct packed {
    alu_op_t            op;
    logic [SEQ_W-1:0]   a;
    logic [SEQ_W-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic [SEQ_W-1:0]   res;
    logic               carry;
  } alu_rsp_t;

endpackage

### hdl/wrr_if.sv
// Valid/ready channel interfaces for packet/space events and for results.
// Depends on wrr_pkg for field widths.
interface wrr_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [wrr_pkg::SEQ_W-1:0]   seqno;
  logic [wrr_pkg::PLEN_W-1:0]  pkt_len;
  logic [wrr_pkg::PLEN_W-1:0]  recv_len;
  logic [wrr_pkg::PLEN_W-1:0]  out_space;

  modport source (output valid, op, seqno, pkt_len, recv_len, out_space, input ready);
  modport sink   (input valid, op, seqno, pkt_len, recv_len, out_space, output ready);
endinterface

interface wrr_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic [wrr_pkg::SEQ_W-1:0]   out_seqno;
  logic [wrr_pkg::LEN_W-1:0]   payload_len;
  logic [wrr_pkg::SEQ_W-1:0]   ack_number;
  logic                        last;

  modport source (output valid, kind, out_seqno, payload_len, ack_number, last, input ready);
  modport sink   (input valid, kind, out_seqno, payload_len, ack_number, last, output ready);
endinterface

### hdl/window_receiver_reorder_core.sv
// Receiver reorder and delivery core: sequencer, reorder store and result register.
// Depends on wrr_pkg, wrr_if, wrr_ram and wrr_alu.
//
// Receiver side of a selective-repeat window. Each event runs through a small
// sequencer that drives one shared 32-bit add/subtract unit, one step a cycle
// save for the output waits below, and in_ch.ready is high only between events.
// A dropped packet runs S_LEN; a held-back end-of-file adds S_WIN; an
// out-of-window or buffered packet also S_ACK; an end-of-file also S_EOF; an
// in-order delivery S_LEN, S_WIN, S_INORD, a store drain and S_ACK. A space
// event ends at S_SPACE with an empty store, otherwise it drains and runs S_ACK
// (up to WINDOW_MAX drains; when that limit ends the drain, the last store
// lookup is skipped). Each drained packet takes the sequence increment, the
// registered store read with the space compare, and the space update. Every
// step that emits a result also waits while the result register is still full
// and out_ch.ready is low. The store is empty after reset with no clearing pass.
module window_receiver_reorder_core (
  input  logic                     clk,
  input  logic                     rst_n,
  wrr_in_if.sink                   in_ch,
  wrr_out_if.source                out_ch,
  input  logic                     cfg_we,
  input  logic [wrr_pkg::WS_W-1:0] cfg_wdata
);
  import wrr_pkg::*;

  state_t               state_r, state_nxt;
  logic [WS_W-1:0]      ws_r;
  logic [SEQ_W-1:0]     ld_r, ld_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [WINDOW_MAX-1:0] full_r, full_nxt;
  logic [PLEN_W-1:0]    space_r, space_nxt;
  logic [SEQ_W-1:0]     off_r, off_nxt;
  logic [LEN_W-1:0]     pay_r, pay_nxt;
  logic [SEQ_W-1:0]     want_r, want_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [CNT_W-1:0]     drn_r, drn_nxt;
  logic                 base_r, base_nxt;
  logic                 eof_r, eof_nxt;

  logic [SEQ_W-1:0]     seq_r;
  logic [PLEN_W-1:0]    plen_r;
  logic [PLEN_W-1:0]    rlen_r;

  logic                 out_valid_r;
  logic [1:0]           out_kind_r;
  logic [SEQ_W-1:0]     out_seq_r;
  logic [LEN_W-1:0]     out_len_r;
  logic [SEQ_W-1:0]     out_ack_r;
  logic                 out_last_r;

  logic                 emit;
  logic [1:0]           e_kind;
  logic [SEQ_W-1:0]     e_seq;
  logic [LEN_W-1:0]     e_len;
  logic [SEQ_W-1:0]     e_ack;
  logic                 e_last;
  logic                 out_free;
  logic                 in_rdy;

  alu_req_t             alu_req;
  alu_rsp_t             alu_rsp;

  logic                 ram_we;
  logic [IDX_W-1:0]     raddr;
  logic [SLOT_W-1:0]    rdata;
  logic [SEQ_W-1:0]     rd_seq;
  logic [LEN_W-1:0]     rd_len;

  logic [IDX_W-1:0]     seq_idx;
  logic [IDX_W-1:0]     want_idx;
  logic [CNT_W-1:0]     win;
  logic                 len_bad;
  logic                 limit_ok;

  wrr_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  wrr_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (WINDOW_MAX)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (seq_idx),
    .wdata ({seq_r, pay_r}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_seq   = rdata[SLOT_W-1:LEN_W];
  assign rd_len   = rdata[LEN_W-1:0];
  assign seq_idx  = seq_r[IDX_W-1:0];
  assign want_idx = want_r[IDX_W-1:0];
  assign out_free = !out_valid_r || out_ch.ready;

  assign win = ({{(32-WS_W){1'b0}}, ws_r} > 32'(WINDOW_MAX)) ? CNT_W'(WINDOW_MAX)
                                                              : CNT_W'(ws_r);

  // short, inconsistent, oversized and ack-length packets all give nothing
  assign len_bad = (rlen_r < ACK_LEN) || (rlen_r < plen_r) || (plen_r < HDR_LEN) ||
                   (plen_r > PLEN_MAX);

  assign limit_ok = (32'(drn_r) < 32'(WINDOW_MAX)) &&
                    ((32'(drn_r) + 32'(base_r)) < 32'(MAX_RESULTS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ws_r    <= WS_RESET;
      ld_r    <= '0;
      cnt_r   <= '0;
      full_r  <= '0;
      base_r  <= 1'b0;
      eof_r   <= 1'b0;
      drn_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        ws_r <= cfg_wdata;
      end
      ld_r    <= ld_nxt;
      cnt_r   <= cnt_nxt;
      full_r  <= full_nxt;
      base_r  <= base_nxt;
      eof_r   <= eof_nxt;
      drn_r   <= drn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    space_r <= space_nxt;
    off_r   <= off_nxt;
    pay_r   <= pay_nxt;
    want_r  <= want_nxt;
    len_r   <= len_nxt;
    if (in_ch.valid && in_rdy) begin
      seq_r  <= in_ch.seqno;
      plen_r <= in_ch.pkt_len;
      rlen_r <= in_ch.recv_len;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ld_nxt    = ld_r;
    cnt_nxt   = cnt_r;
    full_nxt  = full_r;
    space_nxt = space_r;
    off_nxt   = off_r;
    pay_nxt   = pay_r;
    want_nxt  = want_r;
    len_nxt   = len_r;
    drn_nxt   = drn_r;
    base_nxt  = base_r;
    eof_nxt   = eof_r;
    emit      = 1'b0;
    e_kind    = KIND_ACK;
    e_seq     = '0;
    e_len     = '0;
    e_ack     = '0;
    e_last    = 1'b0;
    ram_we    = 1'b0;
    raddr     = seq_idx;
    in_rdy    = 1'b0;
    alu_req   = '{op: ALU_SUB, a: '0, b: '0};

    unique case (state_r)
      S_IDLE: begin
        in_rdy = 1'b1;
        if (in_ch.valid) begin
          state_nxt = in_ch.op ? S_SPACE : S_LEN;
          space_nxt = in_ch.out_space;
          eof_nxt   = 1'b0;
          drn_nxt   = '0;
        end
      end

      S_LEN: begin
        // offset into the window: seq - last_delivered - 1
        alu_req   = '{op: ALU_SUBM1, a: seq_r, b: ld_r};
        off_nxt   = alu_rsp.res;
        pay_nxt   = LEN_W'(plen_r - HDR_LEN);
        state_nxt = (len_bad || (cnt_r >= win)) ? S_IDLE : S_WIN;
      end

      S_WIN: begin
        alu_req = '{op: ALU_SUB, a: off_r, b: 32'(win)};
        if (alu_rsp.carry) begin
          state_nxt = S_ACK;
        end else if (off_r != '0) begin
          if (!full_r[seq_idx]) begin
            full_nxt[seq_idx] = 1'b1;
            cnt_nxt           = cnt_r + 1'b1;
            ram_we            = 1'b1;
          end
          state_nxt = S_ACK;
        end else if (pay_r == '0) begin
          // end-of-file held back while anything is buffered
          if (cnt_r != '0) begin
            state_nxt = S_IDLE;
          end else begin
            ld_nxt    = seq_r;
            eof_nxt   = 1'b1;
            state_nxt = S_ACK;
          end
        end else begin
          state_nxt = S_INORD;
        end
      end

      S_INORD: begin
        alu_req = '{op: ALU_SUB, a: 32'(space_r), b: 32'(pay_r)};
        if (!alu_rsp.carry) begin
          if (!full_r[seq_idx]) begin
            full_nxt[seq_idx] = 1'b1;
            cnt_nxt           = cnt_r + 1'b1;
            ram_we            = 1'b1;
          end
          state_nxt = S_IDLE;
        end else if (out_free) begin
          // a buffered copy of this packet is superseded
          if (full_r[seq_idx] && (rd_seq == seq_r)) begin
            full_nxt[seq_idx] = 1'b0;
            if (cnt_r != '0) begin
              cnt_nxt = cnt_r - 1'b1;
            end
          end
          ld_nxt    = seq_r;
          space_nxt = alu_rsp.res[PLEN_W-1:0];
          emit      = 1'b1;
          e_kind    = KIND_DATA;
          e_seq     = seq_r;
          e_len     = pay_r;
          base_nxt  = 1'b1;
          drn_nxt   = '0;
          state_nxt = S_DRN_A;
        end
      end

      S_SPACE: begin
        if (cnt_r == '0) begin
          state_nxt = S_IDLE;
        end else begin
          base_nxt  = 1'b0;
          drn_nxt   = '0;
          state_nxt = S_DRN_A;
        end
      end

      S_DRN_A: begin
        alu_req = '{op: ALU_INC, a: ld_r, b: '0};
        raddr   = alu_rsp.res[IDX_W-1:0];
        if (!limit_ok) begin
          state_nxt = S_ACK;
        end else begin
          want_nxt  = alu_rsp.res;
          state_nxt = S_DRN_B;
        end
      end

      S_DRN_B: begin
        raddr   = want_idx;
        // stop when the slot does not hold the next packet or space <= len
        alu_req = '{op: ALU_SUB, a: 32'(rd_len), b: 32'(space_r)};
        len_nxt = rd_len;
        if (!full_r[want_idx] || (rd_seq != want_r) || alu_rsp.carry) begin
          state_nxt = S_ACK;
        end else begin
          state_nxt = S_DRN_C;
        end
      end

      S_DRN_C: begin
        raddr   = want_idx;
        alu_req = '{op: ALU_SUB, a: 32'(space_r), b: 32'(len_r)};
        if (out_free) begin
          emit               = 1'b1;
          e_kind             = (len_r == '0) ? KIND_EOF : KIND_DATA;
          e_seq              = want_r;
          e_len              = len_r;
          space_nxt          = alu_rsp.res[PLEN_W-1:0];
          ld_nxt             = want_r;
          full_nxt[want_idx] = 1'b0;
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - 1'b1;
          end
          drn_nxt   = drn_r + 1'b1;
          state_nxt = S_DRN_A;
        end
      end

      S_ACK: begin
        alu_req = '{op: ALU_INC, a: ld_r, b: '0};
        if (out_free) begin
          emit      = 1'b1;
          e_kind    = KIND_ACK;
          e_ack     = alu_rsp.res;
          e_last    = !eof_r;
          state_nxt = eof_r ? S_EOF : S_IDLE;
        end
      end

      S_EOF: begin
        if (out_free) begin
          emit      = 1'b1;
          e_kind    = KIND_EOF;
          e_seq     = seq_r;
          e_last    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= e_kind;
      out_seq_r  <= e_seq;
      out_len_r  <= e_len;
      out_ack_r  <= e_ack;
      out_last_r <= e_last;
    end
  end

  assign in_ch.ready        = in_rdy;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_kind_r;
  assign out_ch.out_seqno   = out_seq_r;
  assign out_ch.payload_len = out_len_r;
  assign out_ch.ack_number  = out_ack_r;
  assign out_ch.last        = out_last_r;

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CNT_W'($countones(full_r)))
    else $error("buffered count out of step with slot flags");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == S_LEN || state_r == S_SPACE))
    else $error("accepted transfer did not start the sequencer");

  a_drain_slot_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRN_C) |-> full_r[want_idx])
    else $error("draining an empty slot");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result register overwritten before transfer");

endmodule

### hdl/wrr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/wrr_alu.sv
// Shared 32-bit add/subtract unit used by the sequencer's arithmetic steps.
// Depends on wrr_pkg for the request and response types.
module wrr_alu (
  input  wrr_pkg::alu_req_t req,
  output wrr_pkg::alu_rsp_t rsp
);
  import wrr_pkg::*;

  logic [SEQ_W-1:0] bb;
  logic             cin;
  logic [SEQ_W:0]   sum;

  always_comb begin
    unique case (req.op)
      ALU_SUB: begin
        bb  = ~req.b;
        cin = 1'b1;
      end
      ALU_SUBM1: begin
        bb  = ~req.b;
        cin = 1'b0;
      end
      ALU_INC: begin
        bb  = '0;
        cin = 1'b1;
      end
      default: begin
        bb  = '0;
        cin = 1'b0;
      end
    endcase
    sum = {1'b0, req.a} + {1'b0, bb} + {{SEQ_W{1'b0}}, cin};
    // carry set on subtract means a >= b
    rsp.res   = sum[SEQ_W-1:0];
    rsp.carry = sum[SEQ_W];
  end

endmodule
